>>> design/tfsync_pkg.sv
// Shared constants, types and CRC helper for the telemetry frame sync block.
`default_nettype none

package tfsync_pkg;

  // Link framing constants.
  localparam logic [7:0]  SYNC_A    = 8'hA5;
  localparam logic [7:0]  SYNC_B    = 8'h5A;
  localparam int          CRC_W     = 16;
  localparam logic [15:0] CRC_POLY  = 16'h8408;
  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam int          STAMP_W   = 48;
  localparam int          COUNT_W   = 32;
  localparam int          ANGLE_W   = 32;

  // Event codes carried on the result channel.
  localparam logic EV_GOOD     = 1'b0;
  localparam logic EV_CRC_FAIL = 1'b1;

  // Control from the frame checker to the byte window.
  typedef struct packed {
    logic step;     // shift one byte into the window
    logic restart;  // a good frame was taken: empty the window
  } win_ctrl_t;

  // Bit-serial reflected CRC over nbits data bits, all zero except the bit
  // at position hot (none when hot is negative), starting from seed. Used
  // only with constant arguments to build the parallel CRC matrix.
  function automatic logic [15:0] crc_unit(input int nbits, input int hot,
                                           input logic [15:0] seed);
    logic [15:0] c;
    logic        fb;
    c = seed;
    for (int n = 0; n < nbits; n++) begin
      fb = c[0] ^ (n == hot);
      c  = {1'b0, c[15:1]} ^ (fb ? CRC_POLY : 16'h0000);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> design/tfsync_crc.sv
// Parallel CRC-16/MCRF4XX over the frame payload, built as XOR trees.
`default_nettype none

module tfsync_crc #(
  parameter int PAYLOAD_WORDS = 8
) (
  input  wire logic [8*4*PAYLOAD_WORDS-1:0] data,
  output logic [tfsync_pkg::CRC_W-1:0]      crc
);

  localparam int DATA_W = 8 * 4 * PAYLOAD_WORDS;

  // Contribution of the init value when every data bit is zero.
  localparam logic [15:0] INIT_TERM =
    tfsync_pkg::crc_unit(DATA_W, -1, tfsync_pkg::CRC_INIT);

  // Which data bits feed CRC output bit k.
  function automatic logic [DATA_W-1:0] crc_mask(input int k);
    logic [DATA_W-1:0] m;
    logic [15:0]       col;
    m = '0;
    for (int j = 0; j < DATA_W; j++) begin
      col  = tfsync_pkg::crc_unit(DATA_W, j, 16'h0000);
      m[j] = col[k];
    end
    return m;
  endfunction

  // Each output bit is an independent XOR tree over its data bits.
  for (genvar k = 0; k < tfsync_pkg::CRC_W; k++) begin : g_bit
    localparam logic [DATA_W-1:0] MASK = crc_mask(k);
    assign crc[k] = (^(data & MASK)) ^ INIT_TERM[k];
  end

endmodule

`default_nettype wire

>>> design/tfsync_window.sv
// Sliding byte window: shift line of the last bytes plus a fill counter.
`default_nettype none

module tfsync_window #(
  parameter int PAYLOAD_WORDS = 8
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire tfsync_pkg::win_ctrl_t          ctrl,
  input  wire logic [7:0]                     new_byte,
  output logic [8*(4*PAYLOAD_WORDS+4)-1:0]    frame,
  output logic                                full
);

  localparam int FRAME_LEN = 4 * PAYLOAD_WORDS + 4;
  localparam int HOLD      = FRAME_LEN - 1;
  localparam int FILL_W    = $clog2(FRAME_LEN);
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(HOLD);

  logic [7:0]        taps [HOLD];
  logic [FILL_W-1:0] fill;
  logic [FILL_W-1:0] fill_next;

  // The window is complete when the incoming byte lands on the last slot.
  assign full = (fill == FILL_MAX);

  // Oldest byte at the bottom, the incoming byte on top.
  always_comb begin
    for (int i = 0; i < HOLD; i++) begin
      frame[8*i +: 8] = taps[i];
    end
    frame[8*HOLD +: 8] = new_byte;
  end

  // Every transaction shifts in; the stored bytes are always the latest ones.
  always_ff @(posedge clk) begin
    if (ctrl.step) begin
      for (int i = 0; i < HOLD - 1; i++) begin
        taps[i] <= taps[i+1];
      end
      taps[HOLD-1] <= new_byte;
    end
  end

  // Fill saturates one below a full frame; a good frame empties the window.
  always_comb begin
    fill_next = fill;
    if (ctrl.step) begin
      if (ctrl.restart) begin
        fill_next = '0;
      end else if (!full) begin
        fill_next = fill + FILL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else begin
      fill <= fill_next;
    end
  end

endmodule

`default_nettype wire

>>> design/telemetry_frame_sync_crc16_core.sv
// Top level of the telemetry frame sync and CRC-16 check block.
//
// Input channel (in_valid/in_ready) carries one received byte and its
// arrival stamp per transaction. The block keeps the last 4*PAYLOAD_WORDS+4
// bytes; once that many bytes are held it looks for the A5 5A header and
// checks CRC-16/MCRF4XX over the payload against the little-endian word in
// the last two bytes. A good frame yields a result with the yaw and pitch
// bit patterns and empties the window; a header with a bad CRC yields an
// error result and slides by one byte. Windows without a header give no
// result. Both totals saturate at all ones.
// A taken byte is checked while it sits in the input register, and any
// result is written to the result register and shown on out_valid. One
// transaction per cycle is sustained unless results stall; the parallel
// CRC tree between the input and result registers sets the cycle time.
// Reset empties the window, clears both totals and drops pending results.
// When the receiver stalls the result register holds, the input register
// fills, and in_ready then drops until the result is taken.
`default_nettype none

module telemetry_frame_sync_crc16_core #(
  parameter int PAYLOAD_WORDS = 8
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [7:0]                        rx_byte,
  input  wire logic [tfsync_pkg::STAMP_W-1:0]    arrival_stamp,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic                                   event_kind,
  output logic [tfsync_pkg::ANGLE_W-1:0]         yaw_bits,
  output logic [tfsync_pkg::ANGLE_W-1:0]         pitch_bits,
  output logic [tfsync_pkg::STAMP_W-1:0]         frame_stamp,
  output logic [tfsync_pkg::COUNT_W-1:0]         good_total,
  output logic [tfsync_pkg::COUNT_W-1:0]         crc_fail_total
);

  localparam int FRAME_LEN = 4 * PAYLOAD_WORDS + 4;
  localparam int CRC_BYTES = 4 * PAYLOAD_WORDS;

  // Input register.
  logic                           s1_valid;
  logic [7:0]                     s1_byte;
  logic [tfsync_pkg::STAMP_W-1:0] s1_stamp;

  logic advance;
  logic step;

  // The check stage moves whenever the result register can take a value.
  assign advance  = !out_valid || out_ready;
  assign step     = s1_valid && advance;
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte  <= rx_byte;
      s1_stamp <= arrival_stamp;
    end
  end

  // Byte window.
  tfsync_pkg::win_ctrl_t       win_ctrl;
  logic [8*FRAME_LEN-1:0]      frame;
  logic                        full;

  tfsync_window #(
    .PAYLOAD_WORDS (PAYLOAD_WORDS)
  ) u_window (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (win_ctrl),
    .new_byte (s1_byte),
    .frame    (frame),
    .full     (full)
  );

  // CRC over the payload bytes that follow the header.
  logic [tfsync_pkg::CRC_W-1:0] crc_got;

  tfsync_crc #(
    .PAYLOAD_WORDS (PAYLOAD_WORDS)
  ) u_crc (
    .data (frame[16 +: 8*CRC_BYTES]),
    .crc  (crc_got)
  );

  // Frame decision.
  logic [tfsync_pkg::CRC_W-1:0] crc_want;
  logic                         header_ok;
  logic                         frame_good;
  logic                         frame_bad;

  assign crc_want   = frame[8*(FRAME_LEN-2) +: 16];
  assign header_ok  = (frame[7:0] == tfsync_pkg::SYNC_A) &&
                      (frame[15:8] == tfsync_pkg::SYNC_B);
  assign frame_good = full && header_ok && (crc_got == crc_want);
  assign frame_bad  = full && header_ok && (crc_got != crc_want);

  assign win_ctrl.step    = step;
  assign win_ctrl.restart = frame_good;

  // Saturating totals.
  logic [tfsync_pkg::COUNT_W-1:0] good_count;
  logic [tfsync_pkg::COUNT_W-1:0] good_count_next;
  logic [tfsync_pkg::COUNT_W-1:0] crc_fail_count;
  logic [tfsync_pkg::COUNT_W-1:0] crc_fail_count_next;

  always_comb begin
    good_count_next     = good_count;
    crc_fail_count_next = crc_fail_count;
    if (frame_good && (good_count != '1)) begin
      good_count_next = good_count + tfsync_pkg::COUNT_W'(1);
    end
    if (frame_bad && (crc_fail_count != '1)) begin
      crc_fail_count_next = crc_fail_count + tfsync_pkg::COUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      good_count     <= '0;
      crc_fail_count <= '0;
    end else if (step) begin
      good_count     <= good_count_next;
      crc_fail_count <= crc_fail_count_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= step && (frame_good || frame_bad);
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      event_kind     <= frame_good ? tfsync_pkg::EV_GOOD : tfsync_pkg::EV_CRC_FAIL;
      yaw_bits       <= frame_good ? frame[16 +: 32] : '0;
      pitch_bits     <= frame_good ? frame[48 +: 32] : '0;
      frame_stamp    <= s1_stamp;
      good_total     <= good_count_next;
      crc_fail_total <= crc_fail_count_next;
    end
  end

endmodule

`default_nettype wire
